FILE: rtl/pctt_pkg.sv
package pctt_pkg;

  localparam int SLOTS = 10;
  // count width holds 0..SLOTS, index width addresses 0..SLOTS-1
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int HANDLE_W = 8;
  localparam int PERIOD_W = 32;
  localparam int USED_W   = 4;
  localparam int MARK_W   = 7;

  // command codes
  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_REGISTER   = 2'd1;
  localparam logic [1:0] CMD_UNREGISTER = 2'd2;
  localparam logic [1:0] CMD_NONE       = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_REG_ANS   = 2'd0;
  localparam logic [1:0] KIND_UNREG_ANS = 2'd1;
  localparam logic [1:0] KIND_FIRE      = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE = 2'd3;

  // register answer status
  localparam logic ST_ACCEPTED = 1'b0;
  localparam logic ST_FULL     = 1'b1;

  // millisecond mark periods
  localparam int MS_10   = 10;
  localparam int MS_20   = 20;
  localparam int MS_100  = 100;
  localparam int MS_200  = 200;
  localparam int MS_500  = 500;
  localparam int MS_1000 = 1000;

  typedef struct packed {
    logic [1:0]          command;
    logic [HANDLE_W-1:0] handle;
    logic [PERIOD_W-1:0] period_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                status;
    logic [HANDLE_W-1:0] fired_handle;
    logic [MARK_W-1:0]   mark_pulses;
    logic [USED_W-1:0]   used_slots;
    logic                last;
  } res_t;

endpackage

FILE: rtl/pctt_front.sv
module pctt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  pctt_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  output pctt_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import pctt_pkg::*;

  // two-entry command queue; unused command codes are dropped on entry
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc, store, take;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  assign acc   = push && !full;
  assign store = acc && (in_cmd.command != CMD_NONE);
  assign take  = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = store ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (store && !take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (take && !store) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

FILE: rtl/pctt_outq.sv
module pctt_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  pctt_pkg::res_t res,
  output logic           res_room,
  output logic           empty,
  output pctt_pkg::res_t out_res,
  input  logic           pop
);
  import pctt_pkg::*;

  // two-entry result queue
  res_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       put, take;

  assign res_room = (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_res  = q_r[rd_ptr_r];

  assign put  = res_valid && res_room;
  assign take = pop && !empty;

  always_comb begin
    wr_ptr_nxt = put ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (put && !take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (take && !put) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

FILE: rtl/pctt_back.sv
module pctt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  pctt_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  output pctt_pkg::res_t res,
  input  logic           res_room
);
  import pctt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TICK  = 4'b0010,
    S_DONE  = 4'b0100,
    S_UNREG = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [HANDLE_W-1:0] slot_handle_r  [SLOTS];
  logic [PERIOD_W-1:0] slot_period_r  [SLOTS];
  logic [PERIOD_W-1:0] slot_elapsed_r [SLOTS];

  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    keep_r, keep_nxt;
  logic [HANDLE_W-1:0] h_r, h_nxt;

  logic [3:0] c10_r, c10_nxt;
  logic [4:0] c20_r, c20_nxt;
  logic [6:0] c100_r, c100_nxt;
  logic [7:0] c200_r, c200_nxt;
  logic [8:0] c500_r, c500_nxt;
  logic [9:0] c1000_r, c1000_nxt;

  logic [IDX_W-1:0]    cur_ix, keep_ix, tail_ix;
  logic [PERIOD_W-1:0] el_inc;
  logic                hit, emit_fire, keep_slot;
  logic                reg_wr, tick_wr, cp_en, zero_en, mark_adv;
  logic [MARK_W-1:0]   marks;
  logic                w10, w20, w100, w200, w500, w1000;

  assign cur_ix    = idx_r[IDX_W-1:0];
  assign keep_ix   = keep_r[IDX_W-1:0];
  assign tail_ix   = total_r[IDX_W-1:0];
  assign el_inc    = slot_elapsed_r[cur_ix] + 32'd1;
  assign hit       = (el_inc >= slot_period_r[cur_ix]);
  assign emit_fire = hit && (slot_handle_r[cur_ix] != '0);
  assign keep_slot = (slot_handle_r[cur_ix] != h_r);

  // a mark is reached when its counter is about to wrap
  assign w10   = (c10_r == 4'(MS_10 - 1));
  assign w20   = (c20_r == 5'(MS_20 - 1));
  assign w100  = (c100_r == 7'(MS_100 - 1));
  assign w200  = (c200_r == 8'(MS_200 - 1));
  assign w500  = (c500_r == 9'(MS_500 - 1));
  assign w1000 = (c1000_r == 10'(MS_1000 - 1));
  assign marks = {w1000, w500, w200, w100, w20, w10, 1'b1};

  assign c10_nxt   = w10 ? '0 : c10_r + 4'd1;
  assign c20_nxt   = w20 ? '0 : c20_r + 5'd1;
  assign c100_nxt  = w100 ? '0 : c100_r + 7'd1;
  assign c200_nxt  = w200 ? '0 : c200_r + 8'd1;
  assign c500_nxt  = w500 ? '0 : c500_r + 9'd1;
  assign c1000_nxt = w1000 ? '0 : c1000_r + 10'd1;

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    keep_nxt   = keep_r;
    h_nxt      = h_r;
    cmd_pop    = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    res.used_slots = USED_W'(total_r);
    reg_wr     = 1'b0;
    tick_wr    = 1'b0;
    cp_en      = 1'b0;
    zero_en    = 1'b0;
    mark_adv   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.command)
            CMD_REGISTER: begin
              if (res_room) begin
                cmd_pop   = 1'b1;
                res_valid = 1'b1;
                res.kind  = KIND_REG_ANS;
                res.last  = 1'b1;
                if (total_r < CNT_W'(SLOTS)) begin
                  reg_wr         = 1'b1;
                  total_nxt      = total_r + CNT_W'(1);
                  res.status     = ST_ACCEPTED;
                  res.used_slots = USED_W'(total_r + CNT_W'(1));
                end else begin
                  res.status = ST_FULL;
                end
              end
            end
            CMD_UNREGISTER: begin
              cmd_pop   = 1'b1;
              h_nxt     = cmd.handle;
              idx_nxt   = '0;
              keep_nxt  = '0;
              state_nxt = S_UNREG;
            end
            CMD_TICK: begin
              cmd_pop   = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_TICK;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_TICK: begin
        if (idx_r < total_r) begin
          if (!emit_fire || res_room) begin
            tick_wr = 1'b1;
            idx_nxt = idx_r + CNT_W'(1);
            if (emit_fire) begin
              res_valid        = 1'b1;
              res.kind         = KIND_FIRE;
              res.fired_handle = slot_handle_r[cur_ix];
            end
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_room) begin
          res_valid       = 1'b1;
          res.kind        = KIND_TICK_DONE;
          res.mark_pulses = marks;
          res.last        = 1'b1;
          mark_adv        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_UNREG: begin
        if (idx_r < total_r) begin
          // copy a kept slot down and clear the place it leaves; clear a removed slot
          cp_en   = keep_slot && (keep_r != idx_r);
          zero_en = !keep_slot || (keep_r != idx_r);
          idx_nxt = idx_r + CNT_W'(1);
          if (keep_slot) begin
            keep_nxt = keep_r + CNT_W'(1);
          end
        end else if (res_room) begin
          total_nxt      = keep_r;
          res_valid      = 1'b1;
          res.kind       = KIND_UNREG_ANS;
          res.used_slots = USED_W'(keep_r);
          res.last       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      idx_r   <= '0;
      keep_r  <= '0;
      h_r     <= '0;
      c10_r   <= '0;
      c20_r   <= '0;
      c100_r  <= '0;
      c200_r  <= '0;
      c500_r  <= '0;
      c1000_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      idx_r   <= idx_nxt;
      keep_r  <= keep_nxt;
      h_r     <= h_nxt;
      if (mark_adv) begin
        c10_r   <= c10_nxt;
        c20_r   <= c20_nxt;
        c100_r  <= c100_nxt;
        c200_r  <= c200_nxt;
        c500_r  <= c500_nxt;
        c1000_r <= c1000_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_handle_r[i]  <= '0;
        slot_period_r[i]  <= '0;
        slot_elapsed_r[i] <= '0;
      end
    end else begin
      if (reg_wr) begin
        slot_handle_r[tail_ix] <= cmd.handle;
        slot_period_r[tail_ix] <= cmd.period_ms;
      end
      if (tick_wr) begin
        slot_elapsed_r[cur_ix] <= hit ? '0 : el_inc;
      end
      if (zero_en) begin
        slot_handle_r[cur_ix]  <= '0;
        slot_period_r[cur_ix]  <= '0;
        slot_elapsed_r[cur_ix] <= '0;
      end
      if (cp_en) begin
        slot_handle_r[keep_ix]  <= slot_handle_r[cur_ix];
        slot_period_r[keep_ix]  <= slot_period_r[cur_ix];
        slot_elapsed_r[keep_ix] <= slot_elapsed_r[cur_ix];
      end
    end
  end

endmodule

FILE: rtl/periodic_callback_timer_table_core.sv
// periodic timer table with up to SLOTS timers, each a handle and a period in
// ticks. words enter through a two-word command queue (push/full) and results
// leave through a two-word result queue (empty/pop), so either side may stall.
// a register command is handled in the idle state of the table sequencer and
// answers with status 0, or status 1 when the table is full. an unregister is
// dispatched, walks every used slot, then answers; it removes every matching
// handle and packs the rest down in order. a tick is dispatched, walks the
// used slots, ends the walk and sends the tick-done word, waiting while the
// result queue is full; every slot whose count reaches its period emits a fire
// word if its handle is nonzero, then a tick-done word carries the 1, 10, 20,
// 100, 200, 500 and 1000 ms mark pulses. command code 3 is dropped at the
// queue and yields no word. the slot walk, one slot per cycle while the
// result queue has room, sets the rate
module periodic_callback_timer_table_core (
  input  logic        clk,
  input  logic        rst_n,
  // command side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_handle,
  input  logic [31:0] in_period_ms,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic        out_status,
  output logic [7:0]  out_fired_handle,
  output logic [6:0]  out_mark_pulses,
  output logic [3:0]  out_used_slots,
  output logic        out_last
);
  import pctt_pkg::*;

  cmd_t in_cmd;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic res_room;

  // pack the input word
  assign in_cmd.command   = in_command;
  assign in_cmd.handle    = in_handle;
  assign in_cmd.period_ms = in_period_ms;

  // front: command queue, drops unused codes
  pctt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: slot table and sequencer that walks it
  pctt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room)
  );

  // result queue toward the consumer
  pctt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .empty     (empty),
    .out_res   (out_res),
    .pop       (pop)
  );

  // unpack the result word
  assign out_kind         = out_res.kind;
  assign out_status       = out_res.status;
  assign out_fired_handle = out_res.fired_handle;
  assign out_mark_pulses  = out_res.mark_pulses;
  assign out_used_slots   = out_res.used_slots;
  assign out_last         = out_res.last;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// periodic timer table: directed corner words, random command mixes under
// several idle/stall patterns, a long result-side hold-off and a run of
// ticks up to the next 100 ms mark. every accepted command word is run through
// a local copy of the table, and the words it should cause are queued and
// matched in order against what comes out
module testbench;
  import pctt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [1:0]  in_command = CMD_TICK;
  logic [7:0]  in_handle = '0;
  logic [31:0] in_period_ms = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  out_kind;
  logic        out_status;
  logic [7:0]  out_fired_handle;
  logic [6:0]  out_mark_pulses;
  logic [3:0]  out_used_slots;
  logic        out_last;

  periodic_callback_timer_table_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_command       (in_command),
    .in_handle        (in_handle),
    .in_period_ms     (in_period_ms),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_fired_handle (out_fired_handle),
    .out_mark_pulses  (out_mark_pulses),
    .out_used_slots   (out_used_slots),
    .out_last         (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the timer table
  logic [HANDLE_W-1:0] tbl_handle  [SLOTS];
  logic [PERIOD_W-1:0] tbl_period  [SLOTS];
  logic [PERIOD_W-1:0] tbl_elapsed [SLOTS];
  int                  tbl_count = 0;
  int                  ms_count = 0;

  // words the table should still produce, oldest first
  res_t timer_words_due [$];

  int fails = 0;

  // idle/stall pattern in percent, and the receiver's hold-off request
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_handle[i] = '0;
      tbl_period[i] = '0;
      tbl_elapsed[i] = '0;
    end
  end

  // queue one expected word; used_slots always reflects the table after the command
  task automatic expect_word(input logic [1:0] kind, input logic status,
                             input logic [7:0] fh, input logic [6:0] marks,
                             input logic last);
    res_t w;
    begin
      w.kind = kind;
      w.status = status;
      w.fired_handle = fh;
      w.mark_pulses = marks;
      w.used_slots = tbl_count[USED_W-1:0];
      w.last = last;
      timer_words_due.push_back(w);
    end
  endtask

  // advance the local table by one accepted command word
  task automatic timer_table_step(input logic [1:0] cmd, input logic [7:0] h,
                                  input logic [31:0] p);
    int keep;
    logic [MARK_W-1:0] marks;
    begin
      case (cmd)
        CMD_REGISTER: begin
          // append at the end; a free slot's elapsed count is already zero
          if (tbl_count < SLOTS) begin
            tbl_handle[tbl_count] = h;
            tbl_period[tbl_count] = p;
            tbl_count++;
            expect_word(KIND_REG_ANS, ST_ACCEPTED, '0, '0, 1'b1);
          end else begin
            expect_word(KIND_REG_ANS, ST_FULL, '0, '0, 1'b1);
          end
        end
        CMD_UNREGISTER: begin
          // drop every matching slot, pack the rest down in order
          keep = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_handle[i] != h) begin
              tbl_handle[keep] = tbl_handle[i];
              tbl_period[keep] = tbl_period[i];
              tbl_elapsed[keep] = tbl_elapsed[i];
              keep++;
            end
          end
          for (int i = keep; i < SLOTS; i++) begin
            tbl_handle[i] = '0;
            tbl_period[i] = '0;
            tbl_elapsed[i] = '0;
          end
          tbl_count = keep;
          expect_word(KIND_UNREG_ANS, 1'b0, '0, '0, 1'b1);
        end
        CMD_TICK: begin
          // walk used slots; zero period fires every tick, zero handle stays silent
          for (int i = 0; i < tbl_count; i++) begin
            tbl_elapsed[i] = tbl_elapsed[i] + 1;
            if (tbl_elapsed[i] >= tbl_period[i]) begin
              tbl_elapsed[i] = '0;
              if (tbl_handle[i] != '0)
                expect_word(KIND_FIRE, 1'b0, tbl_handle[i], '0, 1'b0);
            end
          end
          ms_count++;
          marks = 7'b0000001;
          if (ms_count % MS_10 == 0) marks[1] = 1'b1;
          if (ms_count % MS_20 == 0) marks[2] = 1'b1;
          if (ms_count % MS_100 == 0) marks[3] = 1'b1;
          if (ms_count % MS_200 == 0) marks[4] = 1'b1;
          if (ms_count % MS_500 == 0) marks[5] = 1'b1;
          if (ms_count % MS_1000 == 0) begin
            marks[6] = 1'b1;
            ms_count = 0;
          end
          expect_word(KIND_TICK_DONE, 1'b0, '0, marks, 1'b1);
        end
        default: ; // unused code 3: dropped, no word
      endcase
    end
  endtask

  // offer one command word, possibly after idle cycles, and wait until taken;
  // push stays high on return so back-to-back words never drop it
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] h,
                           input logic [31:0] p);
    begin
      if ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      end
      push <= 1'b1;
      in_command <= cmd;
      in_handle <= h;
      in_period_ms <= p;
      @(posedge clk);
      while (full) @(posedge clk);
      timer_table_step(cmd, h, p);
    end
  endtask

  // sender goes quiet until every expected word has come out
  task automatic drain_results;
    begin
      push <= 1'b0;
      @(posedge clk);
      while (timer_words_due.size() != 0) @(posedge clk);
    end
  endtask

  // mostly ticks and well-formed register/unregister pairs, some noise
  task automatic send_random_word(output bit counted);
    int pick;
    int sel;
    logic [7:0] h;
    logic [31:0] p;
    begin
      pick = $urandom_range(99);
      counted = 1'b1;
      // handles from a small pool so duplicates pile up for unregister
      h = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      sel = $urandom_range(99);
      if (sel < 60) p = $urandom_range(6);
      else if (sel < 85) p = $urandom_range(40, 7);
      else p = $urandom;
      if (pick < 4) begin
        counted = 1'b0;
        send_word(CMD_NONE, 8'($urandom_range(255)), $urandom);
      end else if (pick < 54) begin
        send_word(CMD_TICK, 8'($urandom_range(255)), $urandom);
      end else if (pick < 84) begin
        send_word(CMD_REGISTER, h, p);
      end else begin
        // mostly a handle that is actually in the table
        if (tbl_count > 0 && $urandom_range(3) != 0)
          h = tbl_handle[$urandom_range(tbl_count - 1)];
        send_word(CMD_UNREGISTER, h, $urandom);
      end
    end
  endtask

  // zero period, zero handle, extreme values, duplicate handles,
  // absent handle, unused command code
  task automatic test_special_cases;
    begin
      send_word(CMD_REGISTER, 8'hFF, 32'h0000_0000);
      send_word(CMD_REGISTER, 8'h00, 32'h0000_0001);
      send_word(CMD_REGISTER, 8'h07, 32'h0000_0003);
      send_word(CMD_REGISTER, 8'h07, 32'hFFFF_FFFF);
      send_word(CMD_REGISTER, 8'h01, 32'h0000_0002);
      repeat (4) send_word(CMD_TICK, 8'h00, 32'h0000_0000);
      // both slots with handle 7 go, the others keep their counts
      send_word(CMD_UNREGISTER, 8'h07, 32'hFFFF_FFFF);
      send_word(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
      send_word(CMD_UNREGISTER, 8'h63, 32'h0000_0000);
      send_word(CMD_NONE, 8'hA5, 32'h5A5A_5A5A);
      send_word(CMD_TICK, 8'h00, 32'h0000_0000);
      drain_results();
    end
  endtask

  // fill the table, overflow it twice, then empty it again
  task automatic test_table_full;
    begin
      while (tbl_count < SLOTS)
        send_word(CMD_REGISTER, 8'(tbl_count + 16), 32'(tbl_count));
      repeat (2) send_word(CMD_REGISTER, 8'h80, 32'h0000_0001);
      repeat (2) send_word(CMD_TICK, 8'h00, 32'h0000_0000);
      while (tbl_count > 0) send_word(CMD_UNREGISTER, tbl_handle[0], 32'h0);
      drain_results();
    end
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    int done;
    bit counted;
    begin
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      done = 0;
      while (done < n) begin
        send_random_word(counted);
        if (counted) done++;
      end
      drain_results();
    end
  endtask

  // receiver holds off long enough for both queues to fill and stall the input
  task automatic test_backpressure;
    bit counted;
    begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 400;
      repeat (40) send_random_word(counted);
      drain_results();
    end
  endtask

  // tick up to the next 100 ms mark, passing the 10 and 20 marks on the way
  task automatic test_mark_rollover;
    begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (tbl_count > 0) send_word(CMD_UNREGISTER, tbl_handle[0], 32'h0);
      send_word(CMD_REGISTER, 8'h21, 32'd7);
      send_word(CMD_REGISTER, 8'h42, 32'd250);
      do send_word(CMD_TICK, 8'($urandom_range(255)), $urandom);
      while (ms_count % MS_100 != 0);
      drain_results();
    end
  endtask

  // receiver: random pop, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    begin
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        fails++;
      end
    end
  endtask

  // every popped word is matched against the oldest expectation
  always @(posedge clk) begin : check_words
    res_t want;
    if (rst_n && pop && !empty) begin
      if (timer_words_due.size() == 0) begin
        $error("word with no expectation: kind %0h handle %0h", out_kind,
               out_fired_handle);
        fails++;
      end else begin
        want = timer_words_due.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("status", want.status, out_status);
        check_field("fired_handle", want.fired_handle, out_fired_handle);
        check_field("mark_pulses", want.mark_pulses, out_mark_pulses);
        check_field("used_slots", want.used_slots, out_used_slots);
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_table_full();
    test_random(50, 0, 0);
    test_random(50, 71, 0);
    test_random(50, 0, 71);
    test_random(50, 21, 21);
    test_backpressure();
    test_mark_rollover();
    // let any stray word show up before deciding
    repeat (40) @(posedge clk);
    if (timer_words_due.size() != 0) begin
      $error("%0d expected words never arrived", timer_words_due.size());
      fails++;
    end
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
